/* rtl/core/assert_macros.svh */
// Assertion helpers shared by the core modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle whenever ante holds.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante holds.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/sqmma_pkg.sv */
`default_nettype none

package sqmma_pkg;

  // Field widths
  localparam int IDX_W  = 3;
  localparam int SIZE_W = 4;
  localparam int VAL_W  = 40;
  localparam int AB_W   = 16;
  localparam int PROD_W = 32;

  // Request kinds
  localparam logic [1:0] REQ_LOAD_A  = 2'd0;
  localparam logic [1:0] REQ_LOAD_B  = 2'd1;
  localparam logic [1:0] REQ_LOAD_C  = 2'd2;
  localparam logic [1:0] REQ_COMPUTE = 2'd3;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic                    load_en;
    logic [1:0]              load_sel;
    logic [IDX_W-1:0]        load_row;
    logic [IDX_W-1:0]        load_col;
    logic signed [VAL_W-1:0] load_value;
    logic                    c_rd;
    logic                    issue;
    logic                    issue_last;
    logic [IDX_W-1:0]        i;
    logic [IDX_W-1:0]        j;
    logic [IDX_W-1:0]        k;
    logic                    last_elem;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic done;
    logic out_valid;
  } status_t;

endpackage

`default_nettype wire

/* rtl/core/sqmma_datapath.sv */
`default_nettype none

`include "assert_macros.svh"

module sqmma_datapath #(
  parameter int MAX_N = 8
) (
  input  wire                                    clk,
  input  wire                                    rst,
  input  sqmma_pkg::cmd_t                        cmd,
  output sqmma_pkg::status_t                     status,
  output logic                                   out_valid,
  input  wire                                    out_ready,
  output logic signed [sqmma_pkg::VAL_W-1:0]     out_value,
  output logic [sqmma_pkg::IDX_W-1:0]            out_row,
  output logic [sqmma_pkg::IDX_W-1:0]            out_col,
  output logic                                   out_sat,
  output logic                                   out_last
);
  import sqmma_pkg::*;

  localparam int DEPTH = MAX_N * MAX_N;
  localparam int AW    = $clog2(DEPTH);

  // Clip a load value to signed Q8.8
  function automatic logic signed [AB_W-1:0] sat16(input logic signed [VAL_W-1:0] v);
    logic pos_ovf;
    logic neg_ovf;
    pos_ovf = !v[VAL_W-1] && (|v[VAL_W-2:AB_W-1]);
    neg_ovf = v[VAL_W-1] && !(&v[VAL_W-2:AB_W-1]);
    if (pos_ovf) begin
      sat16 = {1'b0, {(AB_W-1){1'b1}}};
    end else if (neg_ovf) begin
      sat16 = {1'b1, {(AB_W-1){1'b0}}};
    end else begin
      sat16 = v[AB_W-1:0];
    end
  endfunction

  logic signed [AB_W-1:0]   a_mem [DEPTH];
  logic signed [AB_W-1:0]   b_mem [DEPTH];
  logic signed [VAL_W-1:0]  c_mem [DEPTH];
  logic [DEPTH-1:0]         c_valid;

  logic [AW-1:0]            ld_addr;
  logic [AW-1:0]            a_raddr;
  logic [AW-1:0]            b_raddr;
  logic [AW-1:0]            c_addr;
  logic signed [AB_W-1:0]   a_q;
  logic signed [AB_W-1:0]   b_q;
  logic signed [VAL_W-1:0]  c_q;
  logic                     c_q_valid;

  logic                     c_pend;
  logic                     ab_pend;
  logic                     ab_last;
  logic                     prod_pend;
  logic                     prod_last;
  logic signed [PROD_W-1:0] prod;
  logic signed [VAL_W-1:0]  acc;
  logic                     clip;

  logic signed [VAL_W:0]    sum;
  logic                     sum_ovf;
  logic signed [VAL_W-1:0]  sum_sat;
  logic                     done;

  assign ld_addr = AW'(cmd.load_row * MAX_N + cmd.load_col);
  assign a_raddr = AW'(cmd.i * MAX_N + cmd.k);
  assign b_raddr = AW'(cmd.k * MAX_N + cmd.j);
  assign c_addr  = AW'(cmd.i * MAX_N + cmd.j);

  // A store: write on load, read each issued step
  always_ff @(posedge clk) begin
    if (cmd.load_en && cmd.load_sel == REQ_LOAD_A) begin
      a_mem[ld_addr] <= sat16(cmd.load_value);
    end
    a_q <= a_mem[a_raddr];
  end

  // B store
  always_ff @(posedge clk) begin
    if (cmd.load_en && cmd.load_sel == REQ_LOAD_B) begin
      b_mem[ld_addr] <= sat16(cmd.load_value);
    end
    b_q <= b_mem[b_raddr];
  end

  // C store: load or write back of a finished element
  always_ff @(posedge clk) begin
    if (cmd.load_en && cmd.load_sel == REQ_LOAD_C) begin
      c_mem[ld_addr] <= cmd.load_value;
    end else if (done) begin
      c_mem[c_addr] <= sum_sat;
    end
    c_q <= c_mem[c_addr];
  end

  // Track which C entries hold written data; others read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid   <= '0;
      c_q_valid <= 1'b0;
    end else begin
      if (cmd.load_en && cmd.load_sel == REQ_LOAD_C) begin
        c_valid[ld_addr] <= 1'b1;
      end else if (done) begin
        c_valid[c_addr] <= 1'b1;
      end
      c_q_valid <= c_valid[c_addr];
    end
  end

  // Advance the read and multiply pipeline flags
  always_ff @(posedge clk) begin
    if (rst) begin
      c_pend    <= 1'b0;
      ab_pend   <= 1'b0;
      ab_last   <= 1'b0;
      prod_pend <= 1'b0;
      prod_last <= 1'b0;
    end else begin
      c_pend    <= cmd.c_rd;
      ab_pend   <= cmd.issue;
      ab_last   <= cmd.issue && cmd.issue_last;
      prod_pend <= ab_pend;
      prod_last <= ab_last;
    end
  end

  // Register the product
  always_ff @(posedge clk) begin
    prod <= a_q * b_q;
  end

  // Add with saturation to the signed 40-bit range
  assign sum     = {acc[VAL_W-1], acc} + {{(VAL_W+1-PROD_W){prod[PROD_W-1]}}, prod};
  assign sum_ovf = sum[VAL_W] != sum[VAL_W-1];
  assign sum_sat = !sum_ovf ? sum[VAL_W-1:0]
                 : (sum[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}});
  assign done    = prod_pend && prod_last;

  // Accumulator and clip flag
  always_ff @(posedge clk) begin
    if (c_pend) begin
      acc  <= c_q_valid ? c_q : '0;
      clip <= 1'b0;
    end else if (prod_pend) begin
      acc  <= sum_sat;
      clip <= clip | sum_ovf;
    end
  end

  // Output register: load a finished element, drop it when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_value <= sum_sat;
      out_row   <= cmd.i;
      out_col   <= cmd.j;
      out_sat   <= clip | sum_ovf;
      out_last  <= cmd.last_elem;
    end
  end

  assign status.done      = done;
  assign status.out_valid = out_valid;

  `ASSERT_SAME(a_no_overwrite, clk, rst, done, !out_valid, "finished element overwrote a pending item")

endmodule

`default_nettype wire

/* rtl/core/sqmma_controller.sv */
`default_nettype none

`include "assert_macros.svh"

module sqmma_controller #(
  parameter int MAX_N = 8
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire [sqmma_pkg::SIZE_W-1:0]         size_in_use,
  input  wire                                 in_valid,
  output logic                                in_ready,
  input  wire [1:0]                           req_type,
  input  wire [sqmma_pkg::IDX_W-1:0]          row_index,
  input  wire [sqmma_pkg::IDX_W-1:0]          col_index,
  input  wire signed [sqmma_pkg::VAL_W-1:0]   load_value,
  input  sqmma_pkg::status_t                  status,
  output sqmma_pkg::cmd_t                     cmd
);
  import sqmma_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CRD  = 2'd1;
  localparam logic [1:0] ST_MAC  = 2'd2;
  localparam logic [1:0] ST_WAIT = 2'd3;

  localparam logic [SIZE_W-1:0] MAX_N_S = SIZE_W'(MAX_N);

  logic [1:0]        state;
  logic [1:0]        state_next;
  logic [IDX_W-1:0]  i;
  logic [IDX_W-1:0]  i_next;
  logic [IDX_W-1:0]  j;
  logic [IDX_W-1:0]  j_next;
  logic [IDX_W-1:0]  k;
  logic [IDX_W-1:0]  k_next;
  logic [IDX_W-1:0]  n_m1;
  logic [IDX_W-1:0]  n_m1_next;
  logic [SIZE_W-1:0] n_eff;
  logic              in_range;
  logic              last_elem;

  // Clamp the configured size into 1..MAX_N
  always_comb begin
    if (size_in_use == '0) begin
      n_eff = SIZE_W'(1);
    end else if (size_in_use > MAX_N_S) begin
      n_eff = MAX_N_S;
    end else begin
      n_eff = size_in_use;
    end
  end

  assign in_range  = ({1'b0, row_index} < MAX_N_S) && ({1'b0, col_index} < MAX_N_S);
  assign last_elem = (i == n_m1) && (j == n_m1);
  assign in_ready  = state == ST_IDLE;

  // Sequence loads, element reads, multiply steps and write back
  always_comb begin
    state_next = state;
    i_next     = i;
    j_next     = j;
    k_next     = k;
    n_m1_next  = n_m1;
    cmd            = '0;
    cmd.load_sel   = req_type;
    cmd.load_row   = row_index;
    cmd.load_col   = col_index;
    cmd.load_value = load_value;
    cmd.i          = i;
    cmd.j          = j;
    cmd.k          = k;
    cmd.last_elem  = last_elem;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (req_type == REQ_COMPUTE) begin
            i_next     = '0;
            j_next     = '0;
            n_m1_next  = IDX_W'(n_eff - SIZE_W'(1));
            state_next = ST_CRD;
          end else begin
            cmd.load_en = in_range;
          end
        end
      end
      ST_CRD: begin
        if (!status.out_valid) begin
          cmd.c_rd   = 1'b1;
          k_next     = '0;
          state_next = ST_MAC;
        end
      end
      ST_MAC: begin
        cmd.issue      = 1'b1;
        cmd.issue_last = k == n_m1;
        k_next         = k + IDX_W'(1);
        if (k == n_m1) begin
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (status.done) begin
          if (last_elem) begin
            state_next = ST_IDLE;
          end else begin
            if (j == n_m1) begin
              j_next = '0;
              i_next = i + IDX_W'(1);
            end else begin
              j_next = j + IDX_W'(1);
            end
            state_next = ST_CRD;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    i    <= i_next;
    j    <= j_next;
    k    <= k_next;
    n_m1 <= n_m1_next;
  end

  `ASSERT_SAME(a_done_in_wait, clk, rst, status.done, state == ST_WAIT, "element finished outside wait")
  `ASSERT_SAME(a_read_when_free, clk, rst, cmd.c_rd, !status.out_valid, "element started with output busy")
  `ASSERT_NEXT(a_after_done, clk, rst, status.done, state == ST_CRD || state == ST_IDLE, "no advance after element")

endmodule

`default_nettype wire

/* rtl/core/square_matrix_multiply_accumulate.sv */
// Square matrix multiply-accumulate, C += A*B over the leading N x N corner (N from
// size_in_use, clamped to 1..MAX_N). Load items (tuser 0/1/2) write one element of A, B or
// C; A and B are clipped to signed Q8.8, C is Q24.16 and reads as zero after reset until
// written. A compute item (tuser 3) walks the elements in row-major order through one
// multiply-accumulate unit: each element is a C read, then N steps reading A and B from
// their single read ports, then the multiply pipeline (A/B read register, product
// register), and every element after the first waits for the output register to empty.
// Each element is sent as soon as it is finished; tlast marks the final one and tuser
// flags saturation. The next element starts only once the output register is empty.
// No input item is taken while a compute runs.
`default_nettype none

module square_matrix_multiply_accumulate #(
  parameter int MAX_N = 8
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        cfg_we,
  input  wire [3:0]  cfg_wdata,    // size_in_use
  input  wire        s_tvalid,
  output logic       s_tready,
  input  wire [47:0] s_tdata,      // row_index[2:0], col_index[5:3], load_value[45:6], zero
  input  wire [1:0]  s_tuser,      // req_type
  output logic       m_tvalid,
  input  wire        m_tready,
  output logic [47:0] m_tdata,     // result_value[39:0], result_row[42:40],
                                   // result_col[45:43], zero
  output logic       m_tuser,      // saturated
  output logic       m_tlast       // last
);
  import sqmma_pkg::*;

  logic [SIZE_W-1:0]       size_in_use;
  cmd_t                    cmd;
  status_t                 status;
  logic signed [VAL_W-1:0] out_value;
  logic [IDX_W-1:0]        out_row;
  logic [IDX_W-1:0]        out_col;

  // Hold the size register
  always_ff @(posedge clk) begin
    if (rst) begin
      size_in_use <= SIZE_W'(8);
    end else if (cfg_we) begin
      size_in_use <= cfg_wdata;
    end
  end

  sqmma_controller #(
    .MAX_N(MAX_N)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .size_in_use(size_in_use),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .req_type   (s_tuser),
    .row_index  (s_tdata[2:0]),
    .col_index  (s_tdata[5:3]),
    .load_value (s_tdata[45:6]),
    .status     (status),
    .cmd        (cmd)
  );

  sqmma_datapath #(
    .MAX_N(MAX_N)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_value(out_value),
    .out_row  (out_row),
    .out_col  (out_col),
    .out_sat  (m_tuser),
    .out_last (m_tlast)
  );

  assign m_tdata = {2'b00, out_col, out_row, out_value};

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`default_nettype none

module tb_top;
  import sqmma_pkg::*;

  localparam int DIM_MAX = 8;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int ITEMS_PER_PHASE = 3;
  localparam int PRINT_CAP = 200;
  localparam longint C_TOP = 64'sd549755813887;
  localparam longint C_BOTTOM = -64'sd549755813888;
  localparam logic signed [39:0] Q_TOP = 40'sh7FFFFFFFFF;
  localparam logic signed [39:0] Q_BOTTOM = 40'sh8000000000;

  // One emitted C element
  typedef struct {
    logic [39:0] value;
    logic [2:0]  row;
    logic [2:0]  col;
    logic        sat;
    logic        last;
  } elem_t;

  // Mirror of the A, B, C stores and the size register; queues the C elements each
  // compute should emit and checks them as they leave the block.
  class sqmma_checker;
    logic signed [15:0] a_mem [DIM_MAX*DIM_MAX];
    logic signed [15:0] b_mem [DIM_MAX*DIM_MAX];
    longint             c_mem [DIM_MAX*DIM_MAX];
    bit                 a_set [DIM_MAX*DIM_MAX];
    bit                 b_set [DIM_MAX*DIM_MAX];
    logic [3:0]         size_reg;
    elem_t              c_due [$];
    int                 errors;

    function new();
      foreach (c_mem[x]) begin
        c_mem[x] = 0;
        a_mem[x] = '0;
        b_mem[x] = '0;
        a_set[x] = 0;
        b_set[x] = 0;
      end
      size_reg = 4'd8;
      errors = 0;
    endfunction

    // Clamp the register value to 1..DIM_MAX
    function int unsigned span();
      if (size_reg == 4'd0) return 1;
      if (size_reg > DIM_MAX) return DIM_MAX;
      return size_reg;
    endfunction

    function logic signed [15:0] clip_q88(longint v);
      if (v > 32767) return 16'sh7FFF;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
    endfunction

    // Accumulate A*B into C over the corner and queue every element
    function void predict_product();
      int unsigned n;
      int unsigned ci;
      bit          clip [DIM_MAX*DIM_MAX];
      longint      s;
      elem_t       e;
      n = span();
      foreach (clip[x]) clip[x] = 0;
      for (int unsigned i = 0; i < n; i++) begin
        for (int unsigned k = 0; k < n; k++) begin
          for (int unsigned j = 0; j < n; j++) begin
            ci = i * DIM_MAX + j;
            s = c_mem[ci] + longint'(a_mem[i*DIM_MAX+k]) * longint'(b_mem[k*DIM_MAX+j]);
            if (s > C_TOP) begin
              s = C_TOP;
              clip[ci] = 1;
            end else if (s < C_BOTTOM) begin
              s = C_BOTTOM;
              clip[ci] = 1;
            end
            c_mem[ci] = s;
          end
        end
      end
      for (int unsigned i = 0; i < n; i++) begin
        for (int unsigned j = 0; j < n; j++) begin
          ci = i * DIM_MAX + j;
          e.value = c_mem[ci][39:0];
          e.row = i[2:0];
          e.col = j[2:0];
          e.sat = clip[ci];
          e.last = (i == n - 1) && (j == n - 1);
          c_due.insert(c_due.size(), e);
        end
      end
    endfunction

    // Apply one accepted input item
    function void note_item(logic [1:0] kind, logic [2:0] r, logic [2:0] c,
                            logic signed [39:0] v);
      int unsigned idx;
      longint      sv;
      idx = r * DIM_MAX + c;
      sv = v;
      case (kind)
        REQ_LOAD_A: begin
          a_mem[idx] = clip_q88(sv);
          a_set[idx] = 1;
        end
        REQ_LOAD_B: begin
          b_mem[idx] = clip_q88(sv);
          b_set[idx] = 1;
        end
        REQ_LOAD_C: c_mem[idx] = sv;
        default: predict_product();
      endcase
    endfunction

    task flag_mismatch(string msg);
      if (errors < PRINT_CAP) $display("mismatch: %s", msg);
      errors++;
    endtask

    // Compare one emitted element with the oldest one queued
    task check_elem(elem_t got);
      elem_t want;
      if (c_due.size() == 0) begin
        flag_mismatch($sformatf("element (%0d,%0d) with none pending", got.row, got.col));
        return;
      end
      want = c_due.pop_front();
      if (got.value !== want.value)
        flag_mismatch($sformatf("(%0d,%0d) value %h, want %h",
                                want.row, want.col, got.value, want.value));
      if (got.row !== want.row)
        flag_mismatch($sformatf("row %0d, want %0d", got.row, want.row));
      if (got.col !== want.col)
        flag_mismatch($sformatf("col %0d, want %0d", got.col, want.col));
      if (got.sat !== want.sat)
        flag_mismatch($sformatf("(%0d,%0d) saturated %b, want %b",
                                want.row, want.col, got.sat, want.sat));
      if (got.last !== want.last)
        flag_mismatch($sformatf("(%0d,%0d) last %b, want %b",
                                want.row, want.col, got.last, want.last));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [3:0]  cfg_wdata = 4'd0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;    // row_index, col_index, load_value, zero
  logic [1:0]  s_tuser = 2'd0;  // req_type
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;         // result_value, result_row, result_col, zero
  logic        m_tuser;         // saturated
  logic        m_tlast;         // last

  int unsigned send_idle = 0;
  int unsigned recv_stall = 0;
  int          cycle_count = 0;
  sqmma_checker scb = new();

  square_matrix_multiply_accumulate #(
    .MAX_N(DIM_MAX)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always #1 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Stall the result side at random and check every element taken
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      scb.check_elem('{m_tdata[39:0], m_tdata[42:40], m_tdata[45:43], m_tuser, m_tlast});
    m_tready <= ($urandom_range(99) >= recv_stall);
  end

  function automatic logic signed [39:0] rand_wide();
    logic [63:0] t;
    t = {$urandom, $urandom};
    return t[39:0];
  endfunction

  // A and B values: mostly in Q8.8 range, some clipping
  function automatic logic signed [39:0] rand_ab();
    logic signed [39:0] v;
    case ($urandom_range(9))
      0, 1: v = rand_wide();
      2: v = $urandom_range(1) ? 40'sd32767 : -40'sd32768;
      default: begin
        v = $urandom_range(65535);
        v = v - 40'sd32768;
      end
    endcase
    return v;
  endfunction

  // C values: small, close to either rail so products clip, or anything
  function automatic logic signed [39:0] rand_c();
    logic signed [39:0] v;
    case ($urandom_range(9))
      0, 1, 2: begin
        v = $urandom_range(1 << 24);
        v = v - 40'sd8388608;
      end
      3, 4: v = Q_TOP - 40'($urandom);
      5, 6: v = Q_BOTTOM + 40'($urandom);
      default: v = rand_wide();
    endcase
    return v;
  endfunction

  function automatic void set_idling(int mode);
    case (mode % 4)
      0: begin send_idle = 0;  recv_stall = 0;  end
      1: begin send_idle = 59; recv_stall = 0;  end
      2: begin send_idle = 0;  recv_stall = 59; end
      default: begin send_idle = 29; recv_stall = 29; end
    endcase
  endfunction

  // Offer one item, with random gaps before it, and hold until taken
  task automatic send_item(logic [1:0] kind, logic [2:0] r, logic [2:0] c,
                           logic signed [39:0] v);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= {2'b00, v, c, r};
    do @(posedge clk); while (!s_tready);
    scb.note_item(kind, r, c, v);
  endtask

  // Drop valid and hold until every queued element has left the block
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (scb.c_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_size(logic [3:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    scb.size_reg = v;
  endtask

  // Load any A or B entry of the corner not yet written, then start a compute
  task automatic run_compute();
    int unsigned n;
    n = scb.span();
    for (int unsigned r = 0; r < n; r++) begin
      for (int unsigned c = 0; c < n; c++) begin
        if (!scb.a_set[r*DIM_MAX+c]) send_item(REQ_LOAD_A, r[2:0], c[2:0], rand_ab());
        if (!scb.b_set[r*DIM_MAX+c]) send_item(REQ_LOAD_B, r[2:0], c[2:0], rand_ab());
      end
    end
    send_item(REQ_COMPUTE, 3'($urandom_range(7)), 3'($urandom_range(7)), rand_wide());
  endtask

  task automatic random_load();
    logic [1:0] kind;
    kind = 2'($urandom_range(2));
    send_item(kind, 3'($urandom_range(7)), 3'($urandom_range(7)),
              (kind == REQ_LOAD_C) ? rand_c() : rand_ab());
  endtask

  logic [3:0] phase_size [8] = '{4'd1, 4'd3, 4'd0, 4'd15, 4'd8, 4'd4, 4'd2, 4'd6};

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    wait_idle();

    // Directed: 2x2 corner, clipped loads, both rails of C, corner indexes
    write_size(4'd2);
    send_item(REQ_LOAD_A, 3'd0, 3'd0, Q_TOP);
    send_item(REQ_LOAD_A, 3'd0, 3'd1, Q_BOTTOM);
    send_item(REQ_LOAD_A, 3'd1, 3'd0, 40'sd256);
    send_item(REQ_LOAD_A, 3'd1, 3'd1, -40'sd256);
    send_item(REQ_LOAD_A, 3'd7, 3'd7, 40'sd32767);
    send_item(REQ_LOAD_B, 3'd0, 3'd0, 40'sd32767);
    send_item(REQ_LOAD_B, 3'd0, 3'd1, -40'sd32768);
    send_item(REQ_LOAD_B, 3'd1, 3'd0, 40'sd100000);
    send_item(REQ_LOAD_B, 3'd1, 3'd1, -40'sd1);
    send_item(REQ_LOAD_B, 3'd7, 3'd7, -40'sd5);
    send_item(REQ_LOAD_C, 3'd0, 3'd0, Q_TOP);
    send_item(REQ_LOAD_C, 3'd0, 3'd1, Q_BOTTOM);
    send_item(REQ_LOAD_C, 3'd1, 3'd1, 40'sd12345);
    send_item(REQ_LOAD_C, 3'd7, 3'd7, Q_BOTTOM);
    send_item(REQ_COMPUTE, 3'd7, 3'd7, Q_TOP);
    send_item(REQ_COMPUTE, 3'd0, 3'd0, 40'sd0);
    wait_idle();

    // Random phases over several sizes and idling mixes
    for (int p = 0; p < 8; p++) begin
      wait_idle();
      write_size(phase_size[p]);
      set_idling(p);
      for (int m = 0; m < ITEMS_PER_PHASE; m++) begin
        if ($urandom_range(99) < 15) begin
          run_compute();
          if ($urandom_range(3) == 0) wait_idle();
        end else begin
          random_load();
        end
      end
      run_compute();
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (scb.c_due.size() != 0) scb.flag_mismatch("elements still pending at end");
    if (scb.errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

`default_nettype wire
